@@ hdl/beb_pkg.sv @@
// Package for the cubic Bezier easing bisection unit.
// Holds field widths, fixed-point constants and the reciprocal used for the divide by 127.
// No dependencies.
package beb_pkg;

  // Fixed widths of the item fields.
  localparam int CTRL_W = 7;
  localparam int FRAC_BITS = 16;
  localparam int EASED_W = FRAC_BITS + 1;

  // Default number of halvings of the parameter interval.
  localparam int BISECT_STEPS_DEF = 10;

  // Control bytes mean value/127.
  localparam int CTRL_SCALE = 127;

  // Leading coefficient of the cubic: 3*c1 - 3*c2 + 127 lies in -254..508.
  localparam int A3_W = 11;

  // Divide by 127 as a multiply by floor(2^32/127); the estimate is low by at most one.
  localparam int RECIP_SH = 32;
  localparam int RECIP_W = 26;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / CTRL_SCALE);

  // Quotient before the divide by 127 stays below 2^(FRAC_BITS+7).
  localparam int Z_W = FRAC_BITS + 8;

  // Remainder after the estimated quotient stays below 2*127.
  localparam int REM_W = 9;

  localparam logic [EASED_W-1:0] EASED_ONE = EASED_W'(1) << FRAC_BITS;

endpackage

@@ hdl/beb_in_if.sv @@
// Input channel of the easing unit: valid/ready handshake with the control bytes and fraction.
// Depends on beb_pkg for field widths.
interface beb_in_if
  import beb_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CTRL_W-1:0]    ctrl_x1;
  logic [CTRL_W-1:0]    ctrl_y1;
  logic [CTRL_W-1:0]    ctrl_x2;
  logic [CTRL_W-1:0]    ctrl_y2;
  logic [FRAC_BITS-1:0] fraction;

  modport source (output valid, ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2, fraction, input ready);
  modport sink (input valid, ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2, fraction, output ready);
endinterface

@@ hdl/beb_out_if.sv @@
// Output channel of the easing unit: valid/ready handshake with the eased fraction.
// Depends on beb_pkg for the field width.
interface beb_out_if
  import beb_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [EASED_W-1:0] eased;

  modport source (output valid, eased, input ready);
  modport sink (input valid, eased, output ready);
endinterface

@@ hdl/bezier_easing_bisection_unit.sv @@
// Top level of the cubic Bezier easing unit: a fully pipelined bisection on x(s) and
// evaluation of y(s) at the midpoint of the final interval. Depends on beb_pkg, beb_in_if, beb_out_if.
//
//  Port   Direction  Carries                                        Width
//  din    sink       ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2, fraction   7, 7, 7, 7, 16
//  dout   source     eased (Q1.16, at most 1.0)                      17
//
// The unit accepts one item every clock cycle while dout is not stalled. An item passes
// 2*BISECT_STEPS + 5 register stages, two per bisection step plus five. Reset (rst,
// synchronous) clears only the valid bits. When dout holds an item that is not taken, the
// whole pipeline holds and din.ready is low, so nothing is lost or repeated.
module bezier_easing_bisection_unit
  import beb_pkg::*;
#(
  parameter int BISECT_STEPS = BISECT_STEPS_DEF
) (
  input logic      clk,
  input logic      rst,
  beb_in_if.sink   din,
  beb_out_if.source dout
);

  // The parameter s is held as m / D with D = 2^S, so every midpoint is exact.
  // A curve value is the integer cubic P(m) = a3*m^3 + a2*m^2 + a1*m, which equals
  // 127 * D^3 times the curve at s. It stays below 2^(3S+7); the extra headroom covers
  // the signed Taylor terms below.
  localparam int S = BISECT_STEPS + 1;
  localparam int W = 3 * S + 16;
  localparam int TW = W + FRAC_BITS;
  localparam int TT_W = FRAC_BITS + 7;
  localparam int SUM_W = W + FRAC_BITS + 2;

  // Each curve is tracked as its Taylor expansion at the lower end lo of the interval:
  // P(lo+h) = p + d1*h + d2*h^2 + a3*h^3. Steps of h are powers of two, so moving lo
  // forward needs only shifts and adds.
  typedef struct packed {
    logic signed [W-1:0] p;
    logic signed [W-1:0] d1;
    logic signed [W-1:0] d2;
  } poly_t;

  typedef struct packed {
    poly_t                   x;
    poly_t                   y;
    logic signed [A3_W-1:0]  a3x;
    logic signed [A3_W-1:0]  a3y;
    logic [FRAC_BITS-1:0]    t;
  } bis_t;

  // State at lo together with the state at the candidate midpoint lo+h.
  typedef struct packed {
    bis_t  base;
    poly_t cx;
    poly_t cy;
  } cand_t;

  // The whole pipeline advances together unless a finished item waits at the output.
  logic en;
  assign en = !dout.valid || dout.ready;
  assign din.ready = en;

  function automatic logic signed [W-1:0] sext_a3(input logic signed [A3_W-1:0] a);
    return {{(W - A3_W){a[A3_W-1]}}, a};
  endfunction

  // Taylor expansion at lo = 0 for control bytes c1, c2:
  // a1 = 3*c1*D^2, a2 = (3*c2 - 6*c1)*D, a3 = 3*c1 - 3*c2 + 127.
  function automatic poly_t poly_init(input logic [CTRL_W-1:0] c1,
                                      input logic [CTRL_W-1:0] c2);
    logic signed [W-1:0] e1;
    logic signed [W-1:0] e2;
    poly_t r;
    e1 = $signed(W'(c1));
    e2 = $signed(W'(c2));
    r.p = '0;
    r.d1 = (e1 + (e1 <<< 1)) <<< (2 * S);
    r.d2 = (e2 + (e2 <<< 1) - (e1 <<< 1) - (e1 <<< 2)) <<< S;
    return r;
  endfunction

  function automatic logic signed [A3_W-1:0] a3_init(input logic [CTRL_W-1:0] c1,
                                                    input logic [CTRL_W-1:0] c2);
    logic signed [A3_W-1:0] e1;
    logic signed [A3_W-1:0] e2;
    e1 = $signed(A3_W'(c1));
    e2 = $signed(A3_W'(c2));
    return e1 + (e1 <<< 1) - e2 - (e2 <<< 1) + A3_W'(CTRL_SCALE);
  endfunction

  // Moves the expansion point from lo to lo + 2^j.
  function automatic poly_t poly_step(input poly_t a, input logic signed [A3_W-1:0] a3,
                                      input int j);
    logic signed [W-1:0] c3;
    logic signed [W-1:0] c3x3;
    poly_t r;
    c3 = sext_a3(a3);
    c3x3 = c3 + (c3 <<< 1);
    r.p = a.p + (a.d1 <<< j) + (a.d2 <<< (2 * j)) + (c3 <<< (3 * j));
    r.d1 = a.d1 + (a.d2 <<< (j + 1)) + (c3x3 <<< (2 * j));
    r.d2 = a.d2 + (c3x3 <<< j);
    return r;
  endfunction

  // Entry stage.
  bis_t st [BISECT_STEPS+1];
  logic sv [BISECT_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].x   <= poly_init(din.ctrl_x1, din.ctrl_x2);
      st[0].y   <= poly_init(din.ctrl_y1, din.ctrl_y2);
      st[0].a3x <= a3_init(din.ctrl_x1, din.ctrl_x2);
      st[0].a3y <= a3_init(din.ctrl_y1, din.ctrl_y2);
      st[0].t   <= din.fraction;
    end
  end

  // Bisection steps. Step k tests the midpoint lo + 2^(S-1-k): the first register stage
  // forms the candidate expansions, the second compares x against the fraction and keeps
  // either the old lower end or the midpoint.
  cand_t cd [BISECT_STEPS];
  logic  cv [BISECT_STEPS];

  for (genvar k = 0; k < BISECT_STEPS; k++) begin : g_step
    localparam int J = S - 1 - k;

    logic [TT_W-1:0]      tt;
    logic signed [TW-1:0] lhs;
    logic signed [TW-1:0] rhs;
    logic                 below;

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k] <= 1'b0;
      end else if (en) begin
        cv[k] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cd[k].base <= st[k];
        cd[k].cx   <= poly_step(st[k].x, st[k].a3x, J);
        cd[k].cy   <= poly_step(st[k].y, st[k].a3y, J);
      end
    end

    // x(mid) < t, both sides scaled by 127 * D^3 * 2^FRAC_BITS.
    always_comb begin
      tt    = {cd[k].base.t, 7'b0} - TT_W'(cd[k].base.t);
      lhs   = $signed({cd[k].cx.p, {FRAC_BITS{1'b0}}});
      rhs   = $signed(TW'(tt) << (3 * S));
      below = lhs < rhs;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (en) begin
        sv[k+1] <= cv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1].x   <= below ? cd[k].cx : cd[k].base.x;
        st[k+1].y   <= below ? cd[k].cy : cd[k].base.y;
        st[k+1].a3x <= cd[k].base.a3x;
        st[k+1].a3y <= cd[k].base.a3y;
        st[k+1].t   <= cd[k].base.t;
      end
    end
  end

  // After the last step the interval is [lo, lo+2]; y is taken at lo+1.
  logic signed [W-1:0] yval;
  logic                yv;

  always_ff @(posedge clk) begin
    if (rst) begin
      yv <= 1'b0;
    end else if (en) begin
      yv <= sv[BISECT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yval <= st[BISECT_STEPS].y.p + st[BISECT_STEPS].y.d1 + st[BISECT_STEPS].y.d2
              + sext_a3(st[BISECT_STEPS].a3y);
    end
  end

  // Round half up: z = floor((Y * 2^(F+1) + 127*D^3) / 2^(3S+1)); the result is z / 127.
  // Y is never negative, so its bits are taken as unsigned.
  logic [SUM_W-1:0] ysum;
  logic [Z_W-1:0]   zq;
  logic             zv;

  assign ysum = {1'b0, yval, {(FRAC_BITS + 1){1'b0}}} + (SUM_W'(CTRL_SCALE) << (3 * S));

  always_ff @(posedge clk) begin
    if (rst) begin
      zv <= 1'b0;
    end else if (en) begin
      zv <= yv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zq <= ysum[3 * S + 1 +: Z_W];
    end
  end

  // Quotient estimate by reciprocal multiply.
  logic [Z_W+RECIP_W-1:0] prod;
  logic [EASED_W-1:0]     qe;
  logic [Z_W-1:0]         zr;
  logic                   qv;

  assign prod = (Z_W + RECIP_W)'(zq) * (Z_W + RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= 1'b0;
    end else if (en) begin
      qv <= zv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qe <= prod[RECIP_SH +: EASED_W];
      zr <= zq;
    end
  end

  // Correction: the estimate is exact or one too low, told apart by the remainder; the result is clamped to one.
  logic [Z_W-1:0]       rem_full;
  logic [REM_W-1:0]     rem;
  logic [EASED_W:0]     qsum;
  logic [EASED_W-1:0]   qfin;

  always_comb begin
    rem_full = zr - ((Z_W'(qe) << 7) - Z_W'(qe));
    rem      = rem_full[REM_W-1:0];
    qsum     = {1'b0, qe} + ((rem >= REM_W'(CTRL_SCALE)) ? (EASED_W+1)'(1) : '0);
    qfin     = (qsum > (EASED_W+1)'(EASED_ONE)) ? EASED_ONE : qsum[EASED_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= qv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.eased <= qfin;
    end
  end

  // The reciprocal estimate is never off by more than one.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    qv |-> rem < REM_W'(2 * CTRL_SCALE))
    else $error("quotient estimate off by more than one");

  // A held output freezes the pipeline and blocks intake.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.ready |-> !din.ready)
    else $error("intake open while output stalled");

  // An item in the last stage reaches the output register on the next advance.
  a_last_stage: assert property (@(posedge clk) disable iff (rst)
    en && qv |=> dout.valid)
    else $error("item dropped between last stage and output");

  // The eased value never exceeds one.
  a_saturated: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> dout.eased <= EASED_ONE)
    else $error("eased value above one");

endmodule
